/* design/bile_pkg.sv */
package bile_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOCATE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               from_tail;
        logic [POS_W-1:0]   position;
        logic [FUNC_W-1:0]  func;
    } t_req;

    typedef struct packed {
        logic                is_full;
        logic                is_empty;
        logic [COUNT_W-1:0]  count;
        logic [FIDX_W-1:0]   found_index;
        logic [VALUE_W-1:0]  data;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

/* design/bile_seq.sv */
module bile_seq #(
    parameter int CAP    = 16,
    parameter int ELEM_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  bile_pkg::t_req    i_req,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output bile_pkg::t_result o_res
);

    localparam int AW = $clog2(CAP);
    localparam int CW = $clog2(CAP + 1);
    localparam int SW = (ELEM_W < bile_pkg::VALUE_W) ? ELEM_W : bile_pkg::VALUE_W;
    localparam int XW = (CW > bile_pkg::POS_W) ? CW : bile_pkg::POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail, r_free_head, n_free_head;
    logic [CW-1:0] r_count, n_count, r_fresh, n_fresh, r_cnt, n_cnt;
    logic [AW-1:0] r_node, n_node, r_slot, n_slot, r_prev, n_prev;
    logic [bile_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [bile_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                          r_tail_sel, n_tail_sel;
    logic [SW-1:0]                 r_val, n_val, r_data, n_data;
    logic [bile_pkg::STATUS_W-1:0] r_status, n_status;
    logic [bile_pkg::FIDX_W-1:0]   r_fidx, n_fidx;

    logic [SW-1:0] r_elem_mem [CAP];
    logic [AW-1:0] r_next_mem [CAP];
    logic [AW-1:0] r_prev_mem [CAP];
    logic [SW-1:0] r_q_elem;
    logic [AW-1:0] r_q_next, r_q_prev;

    logic [AW-1:0] w_rd_addr;
    logic          w_elem_we, w_next_we, w_prev_we;
    logic [AW-1:0] w_elem_waddr, w_next_waddr, w_next_wdata, w_prev_waddr, w_prev_wdata;
    logic [SW-1:0] w_elem_wdata;
    logic [XW-1:0] w_pos_x, w_cnt_x;
    logic [CW-1:0] w_h_ins, w_h_rd;
    logic          w_pop, w_is_full;
    logic [AW-1:0] w_alloc;

    assign w_pos_x   = XW'(r_pos);
    assign w_cnt_x   = XW'(r_count);
    assign w_h_ins   = CW'(r_tail_sel ? w_cnt_x - w_pos_x : w_pos_x);
    assign w_h_rd    = CW'(r_tail_sel ? w_cnt_x - w_pos_x - XW'(1) : w_pos_x);
    assign w_is_full = (r_count == CW'(CAP));
    assign w_pop     = (r_fresh != r_count);
    assign w_alloc   = w_pop ? r_free_head : AW'(r_fresh);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free_head = r_free_head;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_cnt       = r_cnt;
        n_node      = r_node;
        n_slot      = r_slot;
        n_prev      = r_prev;
        n_func      = r_func;
        n_pos       = r_pos;
        n_tail_sel  = r_tail_sel;
        n_val       = r_val;
        n_status    = r_status;
        n_data      = r_data;
        n_fidx      = r_fidx;
        w_rd_addr    = r_node;
        w_elem_we    = 1'b0;
        w_elem_waddr = w_alloc;
        w_elem_wdata = r_val;
        w_next_we    = 1'b0;
        w_next_waddr = r_node;
        w_next_wdata = r_free_head;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_node;
        w_prev_wdata = r_slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_func     = i_req.func;
                    n_pos      = i_req.position;
                    n_tail_sel = i_req.from_tail;
                    n_val      = SW'(i_req.value);
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_status = bile_pkg::STAT_OK;
                n_data   = '0;
                n_fidx   = '0;
                n_state  = S_DONE;
                case (r_func) inside
                    bile_pkg::FUNC_INSERT: begin
                        if (w_pos_x > w_cnt_x) begin
                            n_status = bile_pkg::STAT_RANGE;
                        end else if (w_is_full) begin
                            n_status = bile_pkg::STAT_FULL;
                        end else begin
                            w_rd_addr = r_free_head;
                            n_cnt     = w_h_ins;
                            n_state   = S_ALLOC;
                        end
                    end
                    bile_pkg::FUNC_ERASE, bile_pkg::FUNC_FIND: begin
                        if (w_pos_x >= w_cnt_x) begin
                            n_status = bile_pkg::STAT_RANGE;
                        end else begin
                            w_rd_addr = r_head;
                            n_node    = r_head;
                            n_cnt     = w_h_rd;
                            n_state   = S_WALK;
                        end
                    end
                    bile_pkg::FUNC_LOCATE: begin
                        w_rd_addr = r_head;
                        n_node    = r_head;
                        n_cnt     = '0;
                        n_state   = S_WALK;
                    end
                    bile_pkg::FUNC_CLEAR: begin
                        n_count = '0;
                        n_fresh = '0;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ALLOC: begin
                if (w_pop) begin
                    n_free_head = r_q_next;
                end else begin
                    n_fresh = r_fresh + CW'(1);
                end
                w_elem_we = 1'b1;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
                if (r_count == '0) begin
                    n_head = w_alloc;
                    n_tail = w_alloc;
                end else if (r_cnt == '0) begin
                    w_next_we    = 1'b1;
                    w_next_waddr = w_alloc;
                    w_next_wdata = r_head;
                    w_prev_we    = 1'b1;
                    w_prev_waddr = r_head;
                    w_prev_wdata = w_alloc;
                    n_head       = w_alloc;
                end else if (r_cnt == r_count) begin
                    w_prev_we    = 1'b1;
                    w_prev_waddr = w_alloc;
                    w_prev_wdata = r_tail;
                    w_next_we    = 1'b1;
                    w_next_waddr = r_tail;
                    w_next_wdata = w_alloc;
                    n_tail       = w_alloc;
                end else begin
                    n_slot    = w_alloc;
                    w_rd_addr = r_head;
                    n_node    = r_head;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                if (r_func == bile_pkg::FUNC_LOCATE) begin
                    if (r_cnt == r_count) begin
                        n_status = bile_pkg::STAT_NOT_FOUND;
                        n_state  = S_DONE;
                    end else if (r_q_elem == r_val) begin
                        n_fidx  = bile_pkg::FIDX_W'(r_cnt);
                        n_state = S_DONE;
                    end else begin
                        w_rd_addr = r_q_next;
                        n_node    = r_q_next;
                        n_cnt     = r_cnt + CW'(1);
                    end
                end else if (r_cnt != '0) begin
                    w_rd_addr = r_q_next;
                    n_node    = r_q_next;
                    n_cnt     = r_cnt - CW'(1);
                end else begin
                    case (r_func)
                        bile_pkg::FUNC_INSERT: begin
                            w_next_we    = 1'b1;
                            w_next_waddr = r_q_prev;
                            w_next_wdata = r_slot;
                            w_prev_we    = 1'b1;
                            w_prev_waddr = r_node;
                            w_prev_wdata = r_slot;
                            n_prev       = r_q_prev;
                            n_state      = S_LINK;
                        end
                        bile_pkg::FUNC_ERASE: begin
                            n_data  = r_q_elem;
                            n_state = S_FREE;
                            if (r_count > CW'(1)) begin
                                if (r_node == r_head) begin
                                    n_head = r_q_next;
                                end else if (r_node == r_tail) begin
                                    n_tail = r_q_prev;
                                end else begin
                                    w_next_we    = 1'b1;
                                    w_next_waddr = r_q_prev;
                                    w_next_wdata = r_q_next;
                                    w_prev_we    = 1'b1;
                                    w_prev_waddr = r_q_next;
                                    w_prev_wdata = r_q_prev;
                                end
                            end
                        end
                        default: begin
                            n_data  = r_q_elem;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LINK: begin
                w_prev_we    = 1'b1;
                w_prev_waddr = r_slot;
                w_prev_wdata = r_prev;
                w_next_we    = 1'b1;
                w_next_waddr = r_slot;
                w_next_wdata = r_node;
                n_state      = S_DONE;
            end
            S_FREE: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_node;
                w_next_wdata = r_free_head;
                n_free_head  = r_node;
                n_count      = r_count - CW'(1);
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_free_head <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free_head <= n_free_head;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_node     <= n_node;
        r_slot     <= n_slot;
        r_prev     <= n_prev;
        r_func     <= n_func;
        r_pos      <= n_pos;
        r_tail_sel <= n_tail_sel;
        r_val      <= n_val;
        r_status   <= n_status;
        r_data     <= n_data;
        r_fidx     <= n_fidx;
    end

    always_ff @(posedge i_clk) begin
        if (w_elem_we) begin
            r_elem_mem[w_elem_waddr] <= w_elem_wdata;
        end
        r_q_elem <= r_elem_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            r_next_mem[w_next_waddr] <= w_next_wdata;
        end
        r_q_next <= r_next_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            r_prev_mem[w_prev_waddr] <= w_prev_wdata;
        end
        r_q_prev <= r_prev_mem[w_rd_addr];
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status      = r_status;
        o_res.data        = bile_pkg::VALUE_W'(r_data);
        o_res.found_index = r_fidx;
        o_res.count       = bile_pkg::COUNT_W'(r_count);
        o_res.is_empty    = (r_count == '0);
        o_res.is_full     = w_is_full;
    end

endmodule

/* design/bounded_indexed_list_engine.sv */
// Channel   Direction  tdata (low bit first)                        tuser
// s_axis    in         position[4:0], from_tail, value[31:0], pad   func[2:0]
// m_axis    out        data[31:0], found_index[3:0], count[4:0],    status[1:0]
//                      is_empty, is_full, pad
// Clear, range errors and unused codes go straight from decode to the result, inserts at
// either end pass through allocation; find and locate walk the links, erase walks and frees
// the node, other inserts allocate, walk and link; the engine then returns to idle.
// Reset leaves an empty list and needs no pass over the memories.
// A result waits in the output register while the next request is taken; the engine
// stalls only when a second result is ready before the first has been transferred.
module bounded_indexed_list_engine #(
    parameter int CAP    = 16,
    parameter int ELEM_W = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // position, from_tail, value
    input  logic [2:0]  i_s_axis_tuser,   // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // data, found_index, count, is_empty, is_full
    output logic [1:0]  o_m_axis_tuser    // status
);

    bile_pkg::t_req    w_req;
    bile_pkg::t_result w_res;
    bile_pkg::t_result r_m_res;
    logic              r_m_valid;
    logic              w_idle, w_res_valid, w_res_ready, w_accept;

    assign w_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_req.func      = i_s_axis_tuser;
    assign w_req.position  = i_s_axis_tdata[4:0];
    assign w_req.from_tail = i_s_axis_tdata[5];
    assign w_req.value     = i_s_axis_tdata[37:6];

    bile_seq #(
        .CAP    (CAP),
        .ELEM_W (ELEM_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_accept),
        .i_req       (w_req),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign o_s_axis_tready = w_idle;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_res.status;
    assign o_m_axis_tdata  = {5'd0, r_m_res.is_full, r_m_res.is_empty, r_m_res.count,
                              r_m_res.found_index, r_m_res.data};

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("Engine took a request while still busy.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_res.status == bile_pkg::STAT_FULL) |-> r_m_res.is_full)
        else $error("Pool-full status reported on a list that is not full.");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_res.status != bile_pkg::STAT_OK) |-> (r_m_res.data == '0))
        else $error("Failed request returned nonzero data.");

    a_empty_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_res.is_empty && r_m_res.is_full))
        else $error("List reported both empty and full.");

endmodule

/* tb/tb_bounded_indexed_list_engine.sv */
`timescale 1ns / 1ps

module tb_bounded_indexed_list_engine;

    localparam int LIST_CAP = 16;

    localparam logic [bile_pkg::FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [bile_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [bile_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // position, from_tail, value, pad
    logic [2:0]  i_s_axis_tuser = '0;   // func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // data, found_index, count, is_empty, is_full, pad
    logic [1:0]  o_m_axis_tuser;        // status

    logic [bile_pkg::VALUE_W-1:0] list_q[$];
    bile_pkg::t_result            expected_results[$];
    int                           failures = 0;
    int                           sender_idle_pct = 0;
    int                           receiver_stall_pct = 0;

    bounded_indexed_list_engine #(
        .CAP    (LIST_CAP),
        .ELEM_W (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Applies one request to the list and returns the result it must produce.
    function automatic bile_pkg::t_result apply_request(
        input logic [bile_pkg::FUNC_W-1:0]  func,
        input logic [bile_pkg::POS_W-1:0]   pos,
        input logic                         from_tail,
        input logic [bile_pkg::VALUE_W-1:0] value);
        bile_pkg::t_result r;
        int                cnt;
        int                h;
        cnt = list_q.size();
        r = '0;
        r.status = bile_pkg::STAT_OK;
        case (func) inside
            bile_pkg::FUNC_INSERT: begin
                if (pos > cnt) begin
                    r.status = bile_pkg::STAT_RANGE;
                end else if (cnt >= LIST_CAP) begin
                    r.status = bile_pkg::STAT_FULL;
                end else begin
                    h = from_tail ? cnt - pos : pos;
                    list_q.insert(h, value);
                end
            end
            bile_pkg::FUNC_ERASE, bile_pkg::FUNC_FIND: begin
                if (pos >= cnt) begin
                    r.status = bile_pkg::STAT_RANGE;
                end else begin
                    h = from_tail ? cnt - 1 - pos : pos;
                    r.data = list_q[h];
                    if (func == bile_pkg::FUNC_ERASE) begin
                        list_q.delete(h);
                    end
                end
            end
            bile_pkg::FUNC_LOCATE: begin
                r.status = bile_pkg::STAT_NOT_FOUND;
                for (int i = 0; i < cnt; i++) begin
                    if (list_q[i] == value) begin
                        r.status = bile_pkg::STAT_OK;
                        r.found_index = i[bile_pkg::FIDX_W-1:0];
                        break;
                    end
                end
            end
            bile_pkg::FUNC_CLEAR: begin
                list_q.delete();
            end
            default: begin
            end
        endcase
        cnt = list_q.size();
        r.count = cnt[bile_pkg::COUNT_W-1:0];
        r.is_empty = (cnt == 0);
        r.is_full = (cnt == LIST_CAP);
        return r;
    endfunction

    task automatic send_request(input logic [bile_pkg::FUNC_W-1:0]  func,
                                input logic [bile_pkg::POS_W-1:0]   pos,
                                input logic                         from_tail,
                                input logic [bile_pkg::VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {2'b00, value, from_tail, pos};
        i_s_axis_tuser <= func;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_results.push_back(apply_request(func, pos, from_tail, value));
    endtask

    always @(posedge i_clk) begin : result_check
        bile_pkg::t_result got;
        bile_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.data = o_m_axis_tdata[31:0];
            got.found_index = o_m_axis_tdata[35:32];
            got.count = o_m_axis_tdata[40:36];
            got.is_empty = o_m_axis_tdata[41];
            got.is_full = o_m_axis_tdata[42];
            got.status = o_m_axis_tuser;
            if (expected_results.size() == 0) begin
                $error("Result transfer with no request outstanding.");
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.data !== want.data) begin
                    $error("data: expected %08h, got %08h", want.data, got.data);
                    failures++;
                end
                if (got.found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, got.found_index);
                    failures++;
                end
                if (got.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, got.count);
                    failures++;
                end
                if (got.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
                    failures++;
                end
                if (got.is_full !== want.is_full) begin
                    $error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
                    failures++;
                end
            end
        end
    end

    function automatic logic [bile_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return $urandom_range(0, 3);
        end else if (r < 23) begin
            return '1;
        end else if (r < 25) begin
            return '0;
        end
        return $urandom();
    endfunction

    task automatic test_insert_limits();
        send_request(bile_pkg::FUNC_INSERT, 5'd1, 1'b0, 32'h1234_5678);
        send_request(bile_pkg::FUNC_INSERT, 5'd0, 1'b0, 32'h0000_0000);
        send_request(bile_pkg::FUNC_INSERT, 5'd0, 1'b1, 32'hFFFF_FFFF);
        for (int i = 2; i < LIST_CAP; i++) begin
            send_request(bile_pkg::FUNC_INSERT, bile_pkg::POS_W'(i / 2), i[0], $urandom());
        end
        send_request(bile_pkg::FUNC_INSERT, 5'd0, 1'b0, 32'hDEAD_BEEF);
        send_request(bile_pkg::FUNC_INSERT, 5'd31, 1'b1, 32'hDEAD_BEEF);
    endtask

    task automatic test_erase_find();
        send_request(bile_pkg::FUNC_FIND, 5'd15, 1'b0, '0);
        send_request(bile_pkg::FUNC_FIND, 5'd16, 1'b1, '0);
        send_request(bile_pkg::FUNC_ERASE, 5'd0, 1'b1, '0);
        send_request(bile_pkg::FUNC_ERASE, 5'd31, 1'b0, '0);
    endtask

    task automatic test_locate();
        send_request(bile_pkg::FUNC_LOCATE, 5'd0, 1'b0, 32'h0000_0000);
        send_request(bile_pkg::FUNC_LOCATE, 5'd0, 1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_clear_and_spare();
        send_request(bile_pkg::FUNC_CLEAR, 5'd31, 1'b1, '1);
        send_request(FUNC_SPARE_7, 5'd0, 1'b0, '0);
        send_request(bile_pkg::FUNC_INSERT, 5'd0, 1'b1, 32'hA5A5_5A5A);
        send_request(FUNC_SPARE_5, 5'd31, 1'b1, '1);
    endtask

    // Inserts dominate in fill stretches and erases in drain stretches so that the
    // list swings between empty and full.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int                           r;
        int                           cnt;
        int                           ins_w;
        int                           era_w;
        logic [bile_pkg::FUNC_W-1:0]  func;
        logic [bile_pkg::POS_W-1:0]   pos;
        logic [bile_pkg::VALUE_W-1:0] value;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            ins_w = ((i / 40) % 2 == 0) ? 55 : 20;
            era_w = ((i / 40) % 2 == 0) ? 15 : 45;
            cnt = list_q.size();
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                func = bile_pkg::FUNC_INSERT;
            end else if (r < ins_w + era_w) begin
                func = bile_pkg::FUNC_ERASE;
            end else if (r < ins_w + era_w + 12) begin
                func = bile_pkg::FUNC_FIND;
            end else if (r < ins_w + era_w + 22) begin
                func = bile_pkg::FUNC_LOCATE;
            end else if (r < ins_w + era_w + 24) begin
                func = bile_pkg::FUNC_CLEAR;
            end else begin
                func = FUNC_SPARE_5 + bile_pkg::FUNC_W'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 99) < 10) begin
                pos = bile_pkg::POS_W'($urandom_range(0, 31));
            end else if (func == bile_pkg::FUNC_INSERT) begin
                pos = bile_pkg::POS_W'($urandom_range(0, cnt));
            end else begin
                pos = bile_pkg::POS_W'($urandom_range(0, (cnt > 0) ? cnt - 1 : 0));
            end
            value = pick_value();
            if (func == bile_pkg::FUNC_LOCATE && cnt > 0 && $urandom_range(0, 99) < 70) begin
                value = list_q[$urandom_range(0, cnt - 1)];
            end
            send_request(func, pos, 1'($urandom_range(0, 1)), value);
        end
    endtask

    initial begin
        int guard;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_insert_limits();
        test_erase_find();
        test_locate();
        test_clear_and_spare();
        test_random_traffic(380, 0, 0);
        test_random_traffic(370, 72, 0);
        test_random_traffic(370, 0, 72);
        test_random_traffic(380, 24, 24);
        i_s_axis_tvalid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived.", expected_results.size());
            failures++;
        end
        repeat (LIST_CAP + 8) @(posedge i_clk);
        if (failures == 0) begin
            $display("[bounded_indexed_list_engine] OK");
        end else begin
            $display("[bounded_indexed_list_engine] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[bounded_indexed_list_engine] ERROR");
        $finish;
    end

endmodule
